[rtl/sbfp_pkg.sv]
// shared types, constants and decode functions for the serial bridge frame parser
package sbfp_pkg;

  localparam int StoreDepth = 30;
  localparam int StoreIdxW  = $clog2(StoreDepth);

  localparam logic [7:0] SYNC_NAV    = 8'hAA;
  localparam logic [7:0] SYNC_FLOAT  = 8'hFF;
  localparam logic [7:0] SYNC_SHORT  = 8'h50;
  localparam logic [7:0] SECOND_STD  = 8'h01;
  localparam logic [7:0] SECOND_SHORT = 8'h41;

  localparam logic [5:0] POS_SUM_A      = 6'd24;
  localparam logic [5:0] POS_SUM_B      = 6'd25;
  localparam logic [5:0] POS_FLOAT_LAST = 6'd59;
  localparam logic [5:0] POS_SHORT_LAST = 6'd18;
  localparam logic [5:0] POS_STORE_END  = 6'(StoreDepth + 2);

  localparam logic [1:0] MODE_FULL    = 2'd1;
  localparam logic [1:0] MODE_HEADING = 2'd2;

  typedef enum logic [1:0] {
    KIND_NAV,
    KIND_FLOAT,
    KIND_SHORT
  } kind_t;

  typedef struct packed {
    logic [1:0]         frame_kind;
    logic               check_error;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic signed [31:0] altitude_cm;
    logic [15:0]        ground_speed;
    logic signed [15:0] roll_tenths;
    logic signed [15:0] pitch_tenths;
    logic signed [15:0] yaw_tenths;
    logic               attitude_valid;
    logic               heading_valid;
  } result_t;

  // ieee single times ten, rounded to 24 bits, truncated and saturated to 16 bits
  function automatic logic signed [15:0] float_tenths(input logic [31:0] bits);
    logic        neg;
    logic [7:0]  ex;
    logic [23:0] m;
    logic [27:0] p;
    logic        sh4;
    logic [24:0] r;
    logic        rnd;
    logic [8:0]  es;
    logic [8:0]  n;
    logic [24:0] mag;
    logic        sat;
    logic        zero;
    logic        big;
    logic signed [15:0] res;
    neg = bits[31];
    ex  = bits[30:23];
    m   = {1'b1, bits[22:0]};
    p   = {1'b0, m, 3'b000} + {3'b000, m, 1'b0};
    sh4 = p[27];
    if (sh4) begin
      r   = {1'b0, p[27:4]};
      rnd = p[3] & ((|p[2:0]) | p[4]);
    end else begin
      r   = {1'b0, p[26:3]};
      rnd = p[2] & ((|p[1:0]) | p[3]);
    end
    r    = r + 25'(rnd);
    es   = {1'b0, ex} + (sh4 ? 9'd4 : 9'd3);
    sat  = (es >= 9'd150);
    n    = 9'd150 - es;
    mag  = (n >= 9'd26) ? 25'd0 : (r >> n[4:0]);
    zero = 1'b0;
    if (ex == 8'hFF) begin
      sat  = 1'b1;
      zero = (bits[22:0] != 23'd0);
    end else if (ex == 8'h00) begin
      zero = 1'b1;
    end
    if (neg) begin
      big = sat | (mag >= 25'd32768);
      res = big ? -16'sd32768 : $signed(~mag[15:0] + 16'd1);
    end else begin
      big = sat | (mag >= 25'd32767);
      res = big ? 16'sd32767 : $signed(mag[15:0]);
    end
    return zero ? 16'sd0 : res;
  endfunction

  // heading wrap into the 0..3600 range, a single wrap that holds for inputs from -3600 to 7200
  function automatic logic signed [15:0] wrap_yaw(input logic signed [15:0] y);
    logic signed [17:0] w;
    w = {{2{y[15]}}, y};
    if (w < 18'sd0) begin
      w = w + 18'sd3600;
    end
    if (w > 18'sd3600) begin
      w = w - 18'sd3600;
    end
    return w[15:0];
  endfunction

endpackage

[rtl/sim_bridge_frame_parser.sv]
// serial bridge frame parser top level
//
//  channel | signals                        | moves
//  --------+--------------------------------+-------------------------------
//  in      | in_valid, in_stall, rx_byte    | one received byte per transfer
//  out     | out_valid, out_stall, fields   | one decoded frame per transfer
//  cfg     | cfg_write, cfg_data            | emulator mode register write
//
// one byte per cycle while in_stall is low: the frame state and the decode of the stored payload,
// including the three float converters, sit between the byte input and the
// result register. a skid register behind the result register keeps input
// open while a result is stalled; in_stall rises only when both hold a result.
// rst is synchronous and returns the parser to sync hunting with sums cleared.
module sim_bridge_frame_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         frame_kind,
  output logic               check_error,
  output logic signed [31:0] latitude,
  output logic signed [31:0] longitude,
  output logic signed [31:0] altitude_cm,
  output logic [15:0]        ground_speed,
  output logic signed [15:0] roll_tenths,
  output logic signed [15:0] pitch_tenths,
  output logic signed [15:0] yaw_tenths,
  output logic               attitude_valid,
  output logic               heading_valid,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_data
);
  import sbfp_pkg::*;

  logic [1:0]  emulator_mode;
  logic [5:0]  byte_position, byte_position_next;
  kind_t       current_kind, current_kind_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  payload [StoreDepth];
  logic        store_en;
  logic [StoreIdxW-1:0] store_idx;

  result_t     res;
  logic        res_gen;
  result_t     out_reg, skid_reg;
  logic        skid_valid;
  logic        accept, res_fire, out_free;

  logic [7:0]  sum_a_add;
  logic [5:0]  last_pos;
  logic [5:0]  store_off;

  assign in_stall = skid_valid;
  assign accept   = in_valid & ~in_stall;
  assign res_fire = accept & res_gen;
  assign out_free = ~out_valid | ~out_stall;

  assign sum_a_add = sum_a + rx_byte;
  assign last_pos  = (current_kind == KIND_FLOAT) ? POS_FLOAT_LAST : POS_SHORT_LAST;
  assign store_off = byte_position - 6'd2;
  assign store_idx = store_off[StoreIdxW-1:0];

  always_comb begin
    byte_position_next = byte_position;
    current_kind_next  = current_kind;
    sum_a_next         = sum_a;
    sum_b_next         = sum_b;
    store_en           = 1'b0;
    res_gen            = 1'b0;
    res                = '0;
    if (byte_position == 6'd0) begin
      if (rx_byte == SYNC_NAV || rx_byte == SYNC_FLOAT || rx_byte == SYNC_SHORT) begin
        current_kind_next  = (rx_byte == SYNC_NAV) ? KIND_NAV :
                             (rx_byte == SYNC_FLOAT) ? KIND_FLOAT : KIND_SHORT;
        sum_a_next         = 8'd0;
        sum_b_next         = 8'd0;
        byte_position_next = 6'd1;
      end
    end else if (byte_position == 6'd1) begin
      if (rx_byte != ((current_kind == KIND_SHORT) ? SECOND_SHORT : SECOND_STD)) begin
        byte_position_next = 6'd0;
        sum_a_next         = 8'd0;
        sum_b_next         = 8'd0;
      end else begin
        byte_position_next = 6'd2;
      end
    end else begin
      unique case (current_kind) inside
        KIND_NAV: begin
          if (byte_position == POS_SUM_A || byte_position == POS_SUM_B) begin
            if (rx_byte != ((byte_position == POS_SUM_A) ? sum_a : sum_b)) begin
              res_gen            = 1'b1;
              res.frame_kind     = KIND_NAV;
              res.check_error    = 1'b1;
              byte_position_next = 6'd0;
              sum_a_next         = 8'd0;
              sum_b_next         = 8'd0;
            end else if (byte_position == POS_SUM_A) begin
              byte_position_next = POS_SUM_B;
            end else begin
              res_gen            = 1'b1;
              res.frame_kind     = KIND_NAV;
              res.latitude       = {payload[3], payload[2], payload[1], payload[0]};
              res.longitude      = {payload[7], payload[6], payload[5], payload[4]};
              res.altitude_cm    = {payload[21], payload[20], payload[19], payload[18]};
              res.ground_speed   = {payload[17], payload[16]};
              res.roll_tenths    = {payload[11], payload[10]};
              res.pitch_tenths   = {payload[13], payload[12]};
              res.yaw_tenths     = wrap_yaw({payload[15], payload[14]});
              res.attitude_valid = (emulator_mode == MODE_FULL);
              res.heading_valid  = (emulator_mode == MODE_FULL) ||
                                   (emulator_mode == MODE_HEADING);
              byte_position_next = 6'd0;
            end
          end else if (byte_position > POS_SUM_B) begin
            byte_position_next = 6'd0;
          end else begin
            store_en           = 1'b1;
            sum_a_next         = sum_a_add;
            sum_b_next         = sum_b + sum_a_add + rx_byte;
            byte_position_next = byte_position + 6'd1;
          end
        end
        KIND_FLOAT, KIND_SHORT: begin
          if (byte_position >= last_pos) begin
            res_gen        = 1'b1;
            res.frame_kind = current_kind;
            if (current_kind == KIND_FLOAT) begin
              res.roll_tenths    = float_tenths({payload[21], payload[20],
                                                 payload[19], payload[18]});
              res.pitch_tenths   = float_tenths({payload[29], payload[28],
                                                 payload[27], payload[26]});
              res.yaw_tenths     = wrap_yaw(float_tenths({payload[25], payload[24],
                                                          payload[23], payload[22]}));
              res.attitude_valid = (emulator_mode == MODE_FULL);
              res.heading_valid  = (emulator_mode == MODE_FULL);
            end
            byte_position_next = 6'd0;
          end else begin
            store_en           = (byte_position < POS_STORE_END);
            byte_position_next = byte_position + 6'd1;
          end
        end
        default: begin
          byte_position_next = 6'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emulator_mode <= 2'd0;
      byte_position <= 6'd0;
      current_kind  <= KIND_NAV;
      sum_a         <= 8'd0;
      sum_b         <= 8'd0;
      out_valid     <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        emulator_mode <= cfg_data;
      end
      if (accept) begin
        byte_position <= byte_position_next;
        current_kind  <= current_kind_next;
        sum_a         <= sum_a_next;
        sum_b         <= sum_b_next;
      end
      if (out_free) begin
        if (skid_valid) begin
          out_reg    <= skid_reg;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_reg    <= res;
          out_valid  <= res_fire;
        end
      end else if (res_fire) begin
        skid_reg   <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_en) begin
      payload[store_idx] <= rx_byte;
    end
  end

  assign frame_kind     = out_reg.frame_kind;
  assign check_error    = out_reg.check_error;
  assign latitude       = out_reg.latitude;
  assign longitude      = out_reg.longitude;
  assign altitude_cm    = out_reg.altitude_cm;
  assign ground_speed   = out_reg.ground_speed;
  assign roll_tenths    = out_reg.roll_tenths;
  assign pitch_tenths   = out_reg.pitch_tenths;
  assign yaw_tenths     = out_reg.yaw_tenths;
  assign attitude_valid = out_reg.attitude_valid;
  assign heading_valid  = out_reg.heading_valid;

endmodule
